FILE: design/erbs_pkg.sv
// ----------------------------------------------------------------------------
// erbs_pkg: shared types and constants of the epoch reply scoreboard
// Function codes, status codes, and the command/status structs that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package erbs_pkg;

    localparam int unsigned MAX_PROGRAMS = 64;
    localparam int unsigned MAP_W        = 64;
    localparam int unsigned EPOCH_W      = 64;
    localparam int unsigned TOTAL_W      = 7;
    localparam int unsigned INDEX_W      = 6;

    localparam logic [1:0] FN_BEGIN   = 2'd0;
    localparam logic [1:0] FN_REPLY   = 2'd1;
    localparam logic [1:0] FN_COLLECT = 2'd2;

    typedef enum logic [3:0] {
        ST_OK      = 4'd0,
        ST_DATA    = 4'd1,
        ST_ARMED   = 4'd2,
        ST_BADARGS = 4'd3,
        ST_PENDING = 4'd4,
        ST_STALE   = 4'd5,
        ST_RANGE   = 4'd6,
        ST_DUP     = 4'd7,
        ST_NOTHING = 4'd8
    } erbs_status_t;

    // controller -> datapath
    typedef struct packed {
        logic take;         // request accepted this cycle
        logic step;         // advance the holder scan by one bit
        logic load_single;  // load a one-shot result into the output register
        logic load_holder;  // load the holder at the scan position
    } erbs_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_start;   // the offered request is a collect that lists holders
        logic hit;          // scan position holds data
        logic last_hit;     // no holder above the scan position
    } erbs_sts_t;

endpackage

FILE: design/erbs_if.sv
// ----------------------------------------------------------------------------
// erbs_if: request and result channels of the epoch reply scoreboard
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface erbs_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    func;
    logic [erbs_pkg::EPOCH_W-1:0]  epoch_tag;
    logic [erbs_pkg::TOTAL_W-1:0]  participant_total;
    logic [erbs_pkg::INDEX_W-1:0]  participant_index;
    logic                          holds_data;

    modport source (
        output valid, func, epoch_tag, participant_total, participant_index, holds_data,
        input  ready
    );
    modport sink (
        input  valid, func, epoch_tag, participant_total, participant_index, holds_data,
        output ready
    );
endinterface

interface erbs_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [3:0]                    status;
    logic [erbs_pkg::INDEX_W-1:0]  holder_index;
    logic [erbs_pkg::INDEX_W-1:0]  holder_rank;
    logic [erbs_pkg::EPOCH_W-1:0]  current_epoch;
    logic                          last;
    logic                          all_answered;
    logic                          collect_armed;
    logic [erbs_pkg::TOTAL_W-1:0]  holder_count;

    modport source (
        output valid, status, holder_index, holder_rank, current_epoch, last,
               all_answered, collect_armed, holder_count,
        input  ready
    );
    modport sink (
        input  valid, status, holder_index, holder_rank, current_epoch, last,
               all_answered, collect_armed, holder_count,
        output ready
    );
endinterface

FILE: design/erbs_ctrl.sv
// ----------------------------------------------------------------------------
// erbs_ctrl: sequencer of the epoch reply scoreboard
// Takes requests, runs the holder scan of a collect, owns result valid.
// ----------------------------------------------------------------------------
module erbs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    input  erbs_pkg::erbs_sts_t sts,
    output erbs_pkg::erbs_cmd_t cmd
);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || rsp_ready;
    assign rsp_valid = out_valid_reg;
    assign req_ready = (state_reg == S_IDLE) && out_free;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.take = req_valid && req_ready;
                if (cmd.take)
                begin
                    if (sts.scan_start)
                        state_next = S_SCAN;
                    else
                        cmd.load_single = 1'b1;
                end
            end
            S_SCAN:
            begin
                if (sts.hit)
                begin
                    if (out_free)
                    begin
                        cmd.load_holder = 1'b1;
                        cmd.step        = 1'b1;
                        if (sts.last_hit)
                            state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (cmd.load_single || cmd.load_holder)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: design/erbs_datapath.sv
// ----------------------------------------------------------------------------
// erbs_datapath: bitmaps, epoch state, holder scan and result register
// Bitmap updates for begin and reply are registered when the request is taken; bit-serial holder scan.
// ----------------------------------------------------------------------------
module erbs_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [1:0]                         func,
    input  logic [erbs_pkg::EPOCH_W-1:0]       epoch_tag,
    input  logic [erbs_pkg::TOTAL_W-1:0]       participant_total,
    input  logic [erbs_pkg::INDEX_W-1:0]       participant_index,
    input  logic                               holds_data,
    input  erbs_pkg::erbs_cmd_t                cmd,
    output erbs_pkg::erbs_sts_t                sts,
    output logic [3:0]                         status,
    output logic [erbs_pkg::INDEX_W-1:0]       holder_index,
    output logic [erbs_pkg::INDEX_W-1:0]       holder_rank,
    output logic [erbs_pkg::EPOCH_W-1:0]       current_epoch,
    output logic                               last,
    output logic                               all_answered,
    output logic                               collect_armed,
    output logic [erbs_pkg::TOTAL_W-1:0]       holder_count
);

    logic [erbs_pkg::MAP_W-1:0]   answered_reg, answered_next;
    logic [erbs_pkg::MAP_W-1:0]   data_reg, data_next;
    logic [erbs_pkg::MAP_W-1:0]   expected_reg, expected_next;
    logic [erbs_pkg::EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [erbs_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic                         pending_reg, pending_next;
    logic [erbs_pkg::TOTAL_W-1:0] count_reg, count_next;

    logic [erbs_pkg::MAP_W-1:0]   sel_reg;
    logic [erbs_pkg::INDEX_W-1:0] idx_reg;
    logic [erbs_pkg::INDEX_W-1:0] rank_reg;

    logic [3:0]                   status_reg;
    logic [erbs_pkg::INDEX_W-1:0] hidx_reg;
    logic [erbs_pkg::INDEX_W-1:0] hrank_reg;
    logic [erbs_pkg::EPOCH_W-1:0] cur_epoch_reg;
    logic                         last_reg;
    logic                         all_ans_reg;
    logic                         armed_reg;
    logic [erbs_pkg::TOTAL_W-1:0] hcount_reg;

    erbs_pkg::erbs_status_t       op_status;
    logic                         complete_now;
    logic                         complete_next;
    logic                         collect_go;
    logic [erbs_pkg::MAP_W-1:0]   sel_init;
    logic [erbs_pkg::MAP_W-1:0]   reply_bit;
    logic [erbs_pkg::MAP_W-1:0]   scan_bit;
    logic [erbs_pkg::MAP_W-1:0]   sel_clr;
    logic [erbs_pkg::MAP_W:0]     mask_wide;

    assign complete_now  = (answered_reg & expected_reg) == expected_reg;
    assign sel_init      = data_reg & expected_reg;
    assign collect_go    = complete_now && pending_reg;
    assign reply_bit     = {{(erbs_pkg::MAP_W-1){1'b0}}, 1'b1} << participant_index;
    assign scan_bit      = {{(erbs_pkg::MAP_W-1){1'b0}}, 1'b1} << idx_reg;
    assign sel_clr       = sel_reg & ~scan_bit;
    assign mask_wide     = ({{erbs_pkg::MAP_W{1'b0}}, 1'b1} << participant_total)
                           - {{erbs_pkg::MAP_W{1'b0}}, 1'b1};

    assign sts.scan_start = (func == erbs_pkg::FN_COLLECT) && collect_go && (sel_init != '0);
    assign sts.hit        = sel_reg[idx_reg];
    assign sts.last_hit   = (sel_clr == '0);

    // next architectural state for the offered request
    always_comb
    begin
        answered_next = answered_reg;
        data_next     = data_reg;
        expected_next = expected_reg;
        epoch_next    = epoch_reg;
        total_next    = total_reg;
        pending_next  = pending_reg;
        count_next    = count_reg;
        op_status     = erbs_pkg::ST_BADARGS;
        unique case (func)
            erbs_pkg::FN_BEGIN:
            begin
                if (participant_total > erbs_pkg::TOTAL_W'(erbs_pkg::MAX_PROGRAMS)
                    || epoch_tag == '0)
                    op_status = erbs_pkg::ST_BADARGS;
                else if (pending_reg)
                    op_status = erbs_pkg::ST_PENDING;
                else
                begin
                    expected_next = mask_wide[erbs_pkg::MAP_W-1:0];
                    answered_next = '0;
                    data_next     = '0;
                    count_next    = '0;
                    total_next    = participant_total;
                    epoch_next    = epoch_tag;
                    op_status     = erbs_pkg::ST_OK;
                end
            end
            erbs_pkg::FN_REPLY:
            begin
                if (epoch_tag != epoch_reg)
                    op_status = erbs_pkg::ST_STALE;
                else if ({1'b0, participant_index} >= total_reg)
                    op_status = erbs_pkg::ST_RANGE;
                else if (answered_reg[participant_index])
                    op_status = erbs_pkg::ST_DUP;
                else
                begin
                    answered_next = answered_reg | reply_bit;
                    if (!holds_data)
                        op_status = erbs_pkg::ST_OK;
                    else
                    begin
                        data_next  = data_reg | reply_bit;
                        count_next = count_reg + 1'b1;
                        if (!pending_reg)
                        begin
                            pending_next = 1'b1;
                            op_status    = erbs_pkg::ST_ARMED;
                        end
                        else
                            op_status = erbs_pkg::ST_DATA;
                    end
                end
            end
            erbs_pkg::FN_COLLECT:
            begin
                // an armed collect with no holders still disarms
                op_status = erbs_pkg::ST_NOTHING;
                if (collect_go)
                    pending_next = 1'b0;
            end
            default: op_status = erbs_pkg::ST_BADARGS;
        endcase
    end

    assign complete_next = (answered_next & expected_next) == expected_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            answered_reg <= '0;
            data_reg     <= '0;
            expected_reg <= '0;
            epoch_reg    <= '0;
            total_reg    <= '0;
            pending_reg  <= 1'b0;
            count_reg    <= '0;
            sel_reg      <= '0;
            idx_reg      <= '0;
            rank_reg     <= '0;
        end
        else
        begin
            if (cmd.take)
            begin
                answered_reg <= answered_next;
                data_reg     <= data_next;
                expected_reg <= expected_next;
                epoch_reg    <= epoch_next;
                total_reg    <= total_next;
                pending_reg  <= pending_next;
                count_reg    <= count_next;
                sel_reg      <= sel_init;
                idx_reg      <= '0;
                rank_reg     <= '0;
            end
            else if (cmd.step)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (cmd.load_holder)
                begin
                    sel_reg  <= sel_clr;
                    rank_reg <= rank_reg + 1'b1;
                end
            end
        end
    end

    // result register, payload only
    always_ff @(posedge clk)
    begin
        if (cmd.load_single)
        begin
            status_reg    <= op_status;
            hidx_reg      <= '0;
            hrank_reg     <= '0;
            cur_epoch_reg <= epoch_next;
            last_reg      <= 1'b1;
            all_ans_reg   <= complete_next;
            armed_reg     <= pending_next;
            hcount_reg    <= count_next;
        end
        else if (cmd.load_holder)
        begin
            status_reg    <= erbs_pkg::ST_OK;
            hidx_reg      <= idx_reg;
            hrank_reg     <= rank_reg;
            cur_epoch_reg <= epoch_reg;
            last_reg      <= sts.last_hit;
            all_ans_reg   <= complete_now;
            armed_reg     <= pending_reg;
            hcount_reg    <= count_reg;
        end
    end

    assign status        = status_reg;
    assign holder_index  = hidx_reg;
    assign holder_rank   = hrank_reg;
    assign current_epoch = cur_epoch_reg;
    assign last          = last_reg;
    assign all_answered  = all_ans_reg;
    assign collect_armed = armed_reg;
    assign holder_count  = hcount_reg;

endmodule

FILE: design/epoch_reply_scoreboard.sv
// ----------------------------------------------------------------------------
// epoch_reply_scoreboard: per-epoch reply tracker for up to 64 participants
// Begin/reply/collect requests in, status results out.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request: func selects begin, reply or collect. Begin and
//   reply (and any refused or unknown request) give exactly one result; a
//   collect that finds every expected reply in and a collect pending lists
//   each data holder in ascending order, one result per holder, last set on
//   the final one. Otherwise collect gives one nothing-collected result.
//   A single result is registered on acceptance and presented in the next cycle.
//   A listing collect scans the data bitmap one bit per cycle, pausing at a
//   holder while the result register cannot be loaded, the rate set by the
//   bit-serial scan counter. Begin and reply sustain one request per cycle
//   while rsp.ready is high; req.ready is low during a scan.
//   The result register decouples the sides: a new request is taken while
//   the previous result is being taken. If rsp.ready stays low, the result
//   holds and req.ready drops; the scan pauses on the holder it waits at.
//   Reset clears all bitmaps, the stored epoch and count, and the pending
//   flag; no result is valid after reset.
// ----------------------------------------------------------------------------
module epoch_reply_scoreboard (
    input  logic        clk,
    input  logic        rst_n,
    erbs_req_if.sink    req,
    erbs_rsp_if.source  rsp
);

    erbs_pkg::erbs_cmd_t cmd;
    erbs_pkg::erbs_sts_t sts;

    // sequencer: handshakes, scan pacing, result valid
    erbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // scoreboard state and result payload
    erbs_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .func              (req.func),
        .epoch_tag         (req.epoch_tag),
        .participant_total (req.participant_total),
        .participant_index (req.participant_index),
        .holds_data        (req.holds_data),
        .cmd               (cmd),
        .sts               (sts),
        .status            (rsp.status),
        .holder_index      (rsp.holder_index),
        .holder_rank       (rsp.holder_rank),
        .current_epoch     (rsp.current_epoch),
        .last              (rsp.last),
        .all_answered      (rsp.all_answered),
        .collect_armed     (rsp.collect_armed),
        .holder_count      (rsp.holder_count)
    );

    // a listing collect closes the request side on the next cycle
    a_scan_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && sts.scan_start) |=> !req.ready)
        else $error("request taken during holder scan");

    // a loaded result is presented on the following cycle
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_single || cmd.load_holder) |=> rsp.valid)
        else $error("loaded result not presented");

    // a holder is never emitted in the same cycle as a new request
    a_take_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.take && (cmd.load_holder || cmd.step)))
        else $error("scan step overlaps request");

    // holder results never carry an armed collect
    a_holder_disarmed: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_holder |=> !rsp.collect_armed)
        else $error("holder result with collect still armed");

endmodule
